>>> rtl/uips_pkg.sv
// uips_pkg: shared constants and types for the user id part splitter
// used by the interfaces, uips_track and user_id_part_splitter_unit
package uips_pkg;

  // default limits
  localparam int unsigned MAX_TEXT_LEN_DEF = 256;
  localparam int unsigned MAX_NEST_DEF     = 15;

  // result field widths
  localparam int unsigned START_W = 8;
  localparam int unsigned LEN_W   = 9;

  // characters the parser reacts to
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_LPAR  = 8'h28;  // '('
  localparam logic [7:0] CH_RPAR  = 8'h29;  // ')'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // part slots
  localparam int unsigned PART_NAME    = 0;
  localparam int unsigned PART_EMAIL   = 1;
  localparam int unsigned PART_COMMENT = 2;
  localparam int unsigned NUM_PARTS    = 3;

  typedef struct packed {
    logic [START_W-1:0] name_start;
    logic [LEN_W-1:0]   name_len;
    logic [START_W-1:0] email_start;
    logic [LEN_W-1:0]   email_len;
    logic [START_W-1:0] comment_start;
    logic [LEN_W-1:0]   comment_len;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic name_open;
    logic email_busy;
    logic comment_busy;
  } track_status_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

>>> rtl/uips_if.sv
// uips_in_if / uips_out_if: valid/ready channels of the part splitter
// depends on uips_pkg for the field widths
interface uips_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface uips_out_if;
  logic                          valid;
  logic                          ready;
  logic [uips_pkg::START_W-1:0] name_start;
  logic [uips_pkg::LEN_W-1:0]   name_len;
  logic [uips_pkg::START_W-1:0] email_start;
  logic [uips_pkg::LEN_W-1:0]   email_len;
  logic [uips_pkg::START_W-1:0] comment_start;
  logic [uips_pkg::LEN_W-1:0]   comment_len;
  logic                          overflow;

  modport source (output valid, output name_start, output name_len, output email_start,
                  output email_len, output comment_start, output comment_len,
                  output overflow, input ready);
  modport sink   (input valid, input name_start, input name_len, input email_start,
                  input email_len, input comment_start, input comment_len,
                  input overflow, output ready);
endinterface

>>> rtl/uips_track.sv
// uips_track: running parse state of one user id text and the part records
// depends on uips_pkg; stepped once per item by the top level
module uips_track #(
  parameter int unsigned MAX_TEXT_LEN = uips_pkg::MAX_TEXT_LEN_DEF,
  parameter int unsigned MAX_NEST     = uips_pkg::MAX_NEST_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              ch,
  input  logic                    end_of_text,
  output uips_pkg::result_t       res,
  output uips_pkg::track_status_t status
);

  localparam int unsigned POS_W = $clog2(MAX_TEXT_LEN + 1);
  localparam int unsigned DEP_W = $clog2(MAX_NEST + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_TEXT_LEN);
  localparam logic [DEP_W-1:0] DEP_LIMIT = DEP_W'(MAX_NEST);
  localparam logic [DEP_W-1:0] DEP_ONE   = DEP_W'(1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             name_open_r, name_open_nxt;
  logic [DEP_W-1:0] email_dep_r, email_dep_nxt;
  logic [DEP_W-1:0] cmt_dep_r, cmt_dep_nxt;
  logic [POS_W-1:0] begin_r, begin_nxt;
  logic [POS_W-1:0] nbend_r, nbend_nxt;
  logic [uips_pkg::NUM_PARTS-1:0] found_r, found_nxt;
  logic             ovf_r, ovf_nxt;
  logic [POS_W-1:0] start_r [uips_pkg::NUM_PARTS];
  logic [POS_W-1:0] len_r   [uips_pkg::NUM_PARTS];

  logic [POS_W-1:0] span_len;
  logic [POS_W-1:0] pos_inc;
  logic [uips_pkg::NUM_PARTS-1:0] rec;
  logic             blank;

  assign span_len = (nbend_r > begin_r) ? (nbend_r - begin_r) : '0;
  assign pos_inc  = pos_r + POS_W'(1);
  assign blank    = uips_pkg::is_blank(ch);

  always_comb begin
    pos_nxt       = pos_r;
    name_open_nxt = name_open_r;
    email_dep_nxt = email_dep_r;
    cmt_dep_nxt   = cmt_dep_r;
    begin_nxt     = begin_r;
    nbend_nxt     = nbend_r;
    ovf_nxt       = ovf_r;
    rec           = '0;
    if (step && end_of_text) begin
      pos_nxt       = '0;
      name_open_nxt = 1'b0;
      email_dep_nxt = '0;
      cmt_dep_nxt   = '0;
      begin_nxt     = '0;
      nbend_nxt     = '0;
      ovf_nxt       = 1'b0;
    end else if (step && (pos_r == POS_LIMIT)) begin
      ovf_nxt = 1'b1;
    end else if (step) begin
      if (email_dep_r != '0) begin
        if (ch == uips_pkg::CH_LT) begin
          if (email_dep_r != DEP_LIMIT) email_dep_nxt = email_dep_r + DEP_ONE;
        end else if (ch == uips_pkg::CH_GT) begin
          email_dep_nxt = email_dep_r - DEP_ONE;
          rec[uips_pkg::PART_EMAIL] = (email_dep_r == DEP_ONE);
        end
      end else if (cmt_dep_r != '0) begin
        if (ch == uips_pkg::CH_LPAR) begin
          if (cmt_dep_r != DEP_LIMIT) cmt_dep_nxt = cmt_dep_r + DEP_ONE;
        end else if (ch == uips_pkg::CH_RPAR) begin
          cmt_dep_nxt = cmt_dep_r - DEP_ONE;
          rec[uips_pkg::PART_COMMENT] = (cmt_dep_r == DEP_ONE);
        end
      end else if ((ch == uips_pkg::CH_LT) || (ch == uips_pkg::CH_LPAR)) begin
        // an opening bracket closes a running name
        rec[uips_pkg::PART_NAME] = name_open_r;
        name_open_nxt = 1'b0;
        if (ch == uips_pkg::CH_LT) email_dep_nxt = DEP_ONE;
        else cmt_dep_nxt = DEP_ONE;
        begin_nxt = pos_inc;
      end else if (!name_open_r && !blank) begin
        name_open_nxt = 1'b1;
        begin_nxt     = pos_r;
      end
      if (!blank) nbend_nxt = pos_inc;
      pos_nxt = pos_inc;
    end
  end

  // only the first occurrence of each part is kept
  always_comb begin
    found_nxt = found_r | rec;
    if (step && end_of_text) found_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      name_open_r <= 1'b0;
      email_dep_r <= '0;
      cmt_dep_r   <= '0;
      begin_r     <= '0;
      nbend_r     <= '0;
      found_r     <= '0;
      ovf_r       <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      name_open_r <= name_open_nxt;
      email_dep_r <= email_dep_nxt;
      cmt_dep_r   <= cmt_dep_nxt;
      begin_r     <= begin_nxt;
      nbend_r     <= nbend_nxt;
      found_r     <= found_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < uips_pkg::NUM_PARTS; k++) begin
      if (rec[k] && !found_r[k]) begin
        start_r[k] <= begin_r;
        len_r[k]   <= span_len;
      end
    end
  end

  // name still running at the end item counts as recorded now
  always_comb begin
    res = '0;
    if (found_r[uips_pkg::PART_NAME]) begin
      res.name_start = uips_pkg::START_W'(start_r[uips_pkg::PART_NAME]);
      res.name_len   = uips_pkg::LEN_W'(len_r[uips_pkg::PART_NAME]);
    end else if (name_open_r) begin
      res.name_start = uips_pkg::START_W'(begin_r);
      res.name_len   = uips_pkg::LEN_W'(span_len);
    end
    if (found_r[uips_pkg::PART_EMAIL]) begin
      res.email_start = uips_pkg::START_W'(start_r[uips_pkg::PART_EMAIL]);
      res.email_len   = uips_pkg::LEN_W'(len_r[uips_pkg::PART_EMAIL]);
    end
    if (found_r[uips_pkg::PART_COMMENT]) begin
      res.comment_start = uips_pkg::START_W'(start_r[uips_pkg::PART_COMMENT]);
      res.comment_len   = uips_pkg::LEN_W'(len_r[uips_pkg::PART_COMMENT]);
    end
    res.overflow = ovf_r;
  end

  assign status.name_open    = name_open_r;
  assign status.email_busy   = (email_dep_r != '0);
  assign status.comment_busy = (cmt_dep_r != '0);

endmodule

>>> rtl/user_id_part_splitter_unit.sv
// user_id_part_splitter_unit: top level, input register, parser, result register
// depends on uips_pkg, uips_in_if / uips_out_if and uips_track
//
// Takes one byte of a user id text per cycle and, on the end item, gives one
// result with the start and trimmed length of the name, email and comment
// parts (0 when absent) plus an overflow flag for bytes past MAX_TEXT_LEN.
// Every item passes through an input register and is folded into the parse
// state as it leaves that register, so the unit sustains one item per clock
// outside stalls; the result enters the output register when the end item
// leaves the input register. Input stalls only when an end item meets a
// result still held in the output register.
module user_id_part_splitter_unit #(
  parameter int unsigned MAX_TEXT_LEN = uips_pkg::MAX_TEXT_LEN_DEF,
  parameter int unsigned MAX_NEST     = uips_pkg::MAX_NEST_DEF
) (
  input logic       clk,
  input logic       rst_n,
  uips_in_if.sink   in_chan,
  uips_out_if.source out_chan
);

  logic       in_vld_r;
  logic [7:0] in_ch_r;
  logic       in_end_r;
  logic       proc;

  logic              out_vld_r;
  uips_pkg::result_t res_r;
  uips_pkg::result_t res;
  uips_pkg::track_status_t status;

  // a held item moves on unless it is an end item and the result slot is full and not being taken
  assign proc = in_vld_r && (!in_end_r || !out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_ch_r  <= in_chan.ch;
      in_end_r <= in_chan.end_of_text;
    end
  end

  uips_track #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN),
    .MAX_NEST     (MAX_NEST)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (proc),
    .ch          (in_ch_r),
    .end_of_text (in_end_r),
    .res         (res),
    .status      (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && in_end_r) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_end_r) res_r <= res;
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.name_start    = res_r.name_start;
  assign out_chan.name_len      = res_r.name_len;
  assign out_chan.email_start   = res_r.email_start;
  assign out_chan.email_len     = res_r.email_len;
  assign out_chan.comment_start = res_r.comment_start;
  assign out_chan.comment_len   = res_r.comment_len;
  assign out_chan.overflow      = res_r.overflow;

`ifndef SYNTHESIS
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_end_r |=> out_vld_r)
    else $error("end item did not load a result");

  a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_end_r |=> !status.name_open && !status.email_busy && !status.comment_busy)
    else $error("parse state not cleared after end item");

  a_one_bracket_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.email_busy && status.comment_busy))
    else $error("email and comment brackets open at once");

  a_no_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_chan.ready |-> !(proc && in_end_r))
    else $error("held result overwritten");
`endif

endmodule
